// ===== sv/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the AABB frustum cull core.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam logic CMD_LOAD_ROW = 1'b0;
    localparam logic CMD_TEST_BOX = 1'b1;

    localparam logic [1:0] ROW_X_IDX = 2'd0;
    localparam logic [1:0] ROW_Y_IDX = 2'd1;
    localparam logic [1:0] ROW_Z_IDX = 2'd2;
    localparam logic [1:0] ROW_W_IDX = 2'd3;

    // Q16.16 plane offset aligned to Q32.32 products
    localparam int D_SHIFT = 16;

    localparam int IN_W     = 32;
    localparam int IN_TDATA = 328;
    localparam int OUT_TDATA = 8;

    typedef struct packed {
        logic valid;
        logic minus;
        logic first;
        logic last;
    } plane_ctl_t;

endpackage

// ===== sv/afc_row_mem.sv =====
// ----------------------------------------------------------------------------
// afc_row_mem
// Matrix row store: one write port, one addressed read port and one read port
// fixed on row w. Per-row valid bits make unwritten rows read as zero.
// ----------------------------------------------------------------------------
module afc_row_mem #(
    parameter int ROW_BITS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_addr,
    input  logic [ROW_BITS-1:0] wr_data,
    input  logic                rd_a_en,
    input  logic [1:0]          rd_a_addr,
    input  logic                rd_b_en,
    output logic [ROW_BITS-1:0] rd_a_data,
    output logic [ROW_BITS-1:0] rd_b_data
);
    import afc_pkg::*;

    logic [ROW_BITS-1:0] mem_reg [4];
    logic [3:0]          row_valid_reg;
    logic [ROW_BITS-1:0] rd_a_reg;
    logic [ROW_BITS-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= row_valid_reg[rd_a_addr] ? mem_reg[rd_a_addr] : '0;
        end
        if (rd_b_en)
        begin
            rd_b_reg <= row_valid_reg[ROW_W_IDX] ? mem_reg[ROW_W_IDX] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== sv/afc_plane_eval.sv =====
// ----------------------------------------------------------------------------
// afc_plane_eval
// Three-stage plane test: coefficients and positive corner, products,
// exact sum and sign. Rejects are OR-ed over the planes of one box.
// ----------------------------------------------------------------------------
module afc_plane_eval #(
    parameter int CW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  afc_pkg::plane_ctl_t ctl,
    input  logic [4*CW-1:0]     row_w,
    input  logic [4*CW-1:0]     row_a,
    input  logic [3*CW-1:0]     box_min,
    input  logic [3*CW-1:0]     box_max,
    output logic                res_valid,
    output logic                res_inside
);
    import afc_pkg::*;

    localparam int CF_W = CW + 1;
    localparam int PW   = CF_W + CW;
    localparam int SW   = 2 * CW + 3;

    plane_ctl_t              a_ctl_reg;
    logic signed [CF_W-1:0]  coef_reg [4];
    logic signed [CW-1:0]    pt_reg [3];
    plane_ctl_t              b_ctl_reg;
    logic signed [PW-1:0]    prod_reg [3];
    logic signed [SW-1:0]    d_reg;
    logic                    rej_acc_reg;
    logic                    res_valid_reg;
    logic                    res_inside_reg;

    logic signed [CF_W-1:0]  coef_next [4];
    logic signed [SW-1:0]    sum;
    logic                    rej;

    always_comb
    begin
        logic signed [CF_W-1:0] w_e;
        logic signed [CF_W-1:0] a_e;
        for (int k = 0; k < 4; k++)
        begin
            w_e = CF_W'($signed(row_w[k*CW +: CW]));
            a_e = CF_W'($signed(row_a[k*CW +: CW]));
            coef_next[k] = ctl.minus ? (w_e - a_e) : (w_e + a_e);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            coef_reg[k] <= coef_next[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            pt_reg[k] <= coef_next[k][CF_W-1] ? $signed(box_min[k*CW +: CW])
                                              : $signed(box_max[k*CW +: CW]);
        end
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= PW'(coef_reg[k]) * PW'(pt_reg[k]);
        end
        d_reg <= SW'(coef_reg[3]) <<< D_SHIFT;
    end

    assign sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + d_reg;
    assign rej = sum[SW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg     <= '0;
            b_ctl_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_ctl_reg     <= ctl;
            b_ctl_reg     <= a_ctl_reg;
            res_valid_reg <= b_ctl_reg.valid && b_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ctl_reg.valid)
        begin
            rej_acc_reg    <= b_ctl_reg.first ? rej : (rej_acc_reg | rej);
            res_inside_reg <= !(rej || (!b_ctl_reg.first && rej_acc_reg));
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_inside = res_inside_reg;

endmodule

// ===== sv/aabb_frustum_cull_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core
// Frustum test of axis-aligned boxes against a stored view-projection matrix.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the command. Command 0 writes one matrix
// row (row_index, row_x..row_w) and gives no result. Command 1 tests a box
// given by its min and max corners and gives one result item.
// Output stream (m_*): inside_res, 1 when no frustum plane has the box fully
// on its negative side.
// A box holds the plane sequencer while its planes run: rows are read from a
// two-port row memory (row w plus one other row), and one plane a cycle goes
// through a three-stage coefficient / multiply / sum pipeline. Row loads pass
// one per cycle while the sequencer is free; a new box starts on the last
// plane step of the box before, and its result goes through the result queue.
// An input register in front of the sequencer takes the next item while the
// current one is at work; a two-entry result queue decouples the output.
// When m_tready stays low, at most two boxes are in flight; a third box then
// waits in the input register and s_tready drops for all further items.
// Reset clears all matrix rows to zero and empties every stage.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row_index[1:0], row_x, row_y, row_z, row_w, min_x, min_y, min_z,
    // max_x, max_y, max_z (32 bits each), zero pad
    input  logic [afc_pkg::IN_TDATA-1:0]  s_tdata,
    // command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inside_res, zero pad
    output logic [afc_pkg::OUT_TDATA-1:0] m_tdata
);
    import afc_pkg::*;

    localparam int EFF_W    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int ROW_BITS = 4 * EFF_W;
    localparam int BOX_BITS = 3 * EFF_W;
    localparam logic [2:0] LAST_STEP = 3'd6;

    logic                slot_vld_reg;
    logic                slot_cmd_reg;
    logic [1:0]          slot_row_reg;
    logic [ROW_BITS-1:0] slot_row_data_reg;
    logic [BOX_BITS-1:0] slot_min_reg;
    logic [BOX_BITS-1:0] slot_max_reg;

    logic                busy_reg;
    logic                busy_next;
    logic [2:0]          step_reg;
    logic [2:0]          step_next;
    logic [BOX_BITS-1:0] box_min_reg;
    logic [BOX_BITS-1:0] box_max_reg;
    logic [1:0]          pend_reg;
    logic [1:0]          pend_next;

    logic                fifo_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          fcnt_reg;
    logic [1:0]          fcnt_next;

    logic                in_acc;
    logic                out_acc;
    logic                seq_free;
    logic                take;
    logic                box_start;
    logic                mem_we;
    logic                rd_a_en;
    logic [1:0]          rd_a_addr;
    logic [ROW_BITS-1:0] rd_a_data;
    logic [ROW_BITS-1:0] rd_b_data;
    logic [ROW_BITS-1:0] in_row;
    logic [BOX_BITS-1:0] in_min;
    logic [BOX_BITS-1:0] in_max;
    plane_ctl_t          ctl;
    logic                res_valid;
    logic                res_inside;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            in_row[k*EFF_W +: EFF_W] = s_tdata[2 + k*IN_W +: EFF_W];
        end
        for (int k = 0; k < 3; k++)
        begin
            in_min[k*EFF_W +: EFF_W] = s_tdata[2 + (4 + k)*IN_W +: EFF_W];
            in_max[k*EFF_W +: EFF_W] = s_tdata[2 + (7 + k)*IN_W +: EFF_W];
        end
    end

    assign seq_free  = !busy_reg || (step_reg == LAST_STEP);
    assign take      = slot_vld_reg && seq_free &&
                       ((slot_cmd_reg == CMD_LOAD_ROW) || (pend_reg < 2'd2));
    assign box_start = take && (slot_cmd_reg == CMD_TEST_BOX);
    assign mem_we    = take && (slot_cmd_reg == CMD_LOAD_ROW);
    assign s_tready  = !slot_vld_reg || take;
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            slot_vld_reg <= 1'b1;
        end
        else if (take)
        begin
            slot_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            slot_cmd_reg      <= s_tuser;
            slot_row_reg      <= s_tdata[1:0];
            slot_row_data_reg <= in_row;
            slot_min_reg      <= in_min;
            slot_max_reg      <= in_max;
        end
        if (box_start)
        begin
            box_min_reg <= slot_min_reg;
            box_max_reg <= slot_max_reg;
        end
    end

    // the take cycle sets step 1; planes run on steps 1..6
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (box_start)
        begin
            busy_next = 1'b1;
            step_next = 3'd1;
        end
        else if (busy_reg)
        begin
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    assign rd_a_en   = box_start || (busy_reg && (step_reg == 3'd2 || step_reg == 3'd4));
    assign rd_a_addr = box_start ? ROW_X_IDX : ((step_reg == 3'd2) ? ROW_Y_IDX : ROW_Z_IDX);

    assign ctl.valid = busy_reg;
    assign ctl.minus = !step_reg[0];
    assign ctl.first = (step_reg == 3'd1);
    assign ctl.last  = (step_reg == LAST_STEP);

    always_comb
    begin
        pend_next = pend_reg;
        if (box_start && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!box_start && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_comb
    begin
        fcnt_next = fcnt_reg;
        if (res_valid && !out_acc)
        begin
            fcnt_next = fcnt_reg + 2'd1;
        end
        else if (!res_valid && out_acc)
        begin
            fcnt_next = fcnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= 3'd0;
            pend_reg   <= 2'd0;
            fcnt_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            pend_reg <= pend_next;
            fcnt_reg <= fcnt_next;
            if (res_valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (out_acc)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_reg[wr_ptr_reg] <= res_inside;
        end
    end

    assign m_tvalid = (fcnt_reg != 2'd0);
    assign m_tdata  = {{(OUT_TDATA-1){1'b0}}, fifo_reg[rd_ptr_reg]};

    afc_row_mem #(
        .ROW_BITS (ROW_BITS)
    ) u_row_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (mem_we),
        .wr_addr   (slot_row_reg),
        .wr_data   (slot_row_data_reg),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_b_en   (box_start),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    afc_plane_eval #(
        .CW (EFF_W)
    ) u_plane_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .row_w      (rd_b_data),
        .row_a      (rd_a_data),
        .box_min    (box_min_reg),
        .box_max    (box_max_reg),
        .res_valid  (res_valid),
        .res_inside (res_inside)
    );

endmodule
